// ===== rtl/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants of the polygon plane clipper
// Vertex store entry, side and status codes, register indexes, control states.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int MAX_VERTS = 32;

  // configuration register indexes
  localparam logic [2:0] REG_NORMAL_X   = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y   = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z   = 3'd2;
  localparam logic [2:0] REG_PLANE_DIST = 3'd3;
  localparam logic [2:0] REG_EPSILON    = 3'd4;

  // reset values: normal (0, 0, 1.0) in Q2.30, epsilon about 0.001 in Q16.16
  localparam logic [31:0] NORMAL_Z_RESET = 32'h4000_0000;
  localparam logic [15:0] EPSILON_RESET  = 16'd66;

  typedef enum logic [1:0] {
    SIDE_ON    = 2'd0,
    SIDE_FRONT = 2'd1,
    SIDE_BACK  = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    STAT_CLIPPED   = 2'd0,
    STAT_UNCHANGED = 2'd1,
    STAT_REMOVED   = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } clip_status_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sdist;
    side_t       side;
  } vtx_entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_X,
    S_LD_Y,
    S_LD_Z,
    S_LD_ACC,
    S_LD_WR,
    S_CLOSE,
    S_U_RD,
    S_U_EMIT,
    S_C_RD0,
    S_C_LD0,
    S_C_RDN,
    S_C_GOTN,
    S_C_KEEP,
    S_C_MUL,
    S_C_DIVGO,
    S_C_DIVW,
    S_C_EMI,
    S_C_ADV,
    S_STAT
  } ctl_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // edge ends lie strictly on opposite sides
  function automatic logic is_cross(side_t a, side_t b);
    return ((a == SIDE_FRONT) && (b == SIDE_BACK)) ||
           ((a == SIDE_BACK) && (b == SIDE_FRONT));
  endfunction

endpackage

// ===== rtl/ppc_if.sv =====
// ----------------------------------------------------------------------------
// ppc_if: channel interfaces of the polygon plane clipper
// Vertex input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ppc_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface ppc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               vertex_present;
  logic               final_result;
  logic [1:0]         clip_status;

  modport source (output valid, out_x, out_y, out_z, vertex_present, final_result,
                  clip_status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, vertex_present, final_result,
                  clip_status, output ready);
endinterface

interface ppc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/polygon_plane_clipper.sv =====
// ----------------------------------------------------------------------------
// polygon_plane_clipper: clips one convex polygon against a plane
// Keeps the back side; loads vertices into a store, then emits the result.
// ----------------------------------------------------------------------------
// Usage:
//   in_vtx  : one vertex per transfer, last_vertex closes the polygon.
//   out_res : result vertices of a polygon, final_result on the last one;
//             removed and overflow polygons give one status-only result.
//   cfg_wr  : register writes (normal x/y/z, plane distance, epsilon), always
//             ready; write only while the block is idle.
// Loading: a vertex is taken while idle, then loaded (three products through one
//   33x33 multiplier, accumulate, saturate and store) before the next is taken.
//   Vertices beyond MAX_VERTS are taken and dropped.
// After the last vertex: unchanged polygons stream the store, a read and an
//   emit per vertex; clipped polygons read, keep and advance per stored vertex
//   and run three divides in the divider per crossing edge.
// The store is a synchronous memory with one write and one read port; no clearing pass is needed.
// Reset returns the registers to their defaults and empties the store.
// A stalled receiver holds the output register; the sequencer waits on it,
//   and input is taken only while loading.
// ----------------------------------------------------------------------------
module polygon_plane_clipper #(
  parameter int MAX_VERTS = ppc_pkg::MAX_VERTS
) (
  input logic       clk,
  input logic       rst_n,
  ppc_vtx_if.sink   in_vtx,
  ppc_res_if.source out_res,
  ppc_cfg_if.sink   cfg_wr
);

  localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int TW = $clog2(2 * MAX_VERTS + 1);

  // configuration registers
  logic [31:0] nx_r, ny_r, nz_r, pd_r;
  logic [15:0] eps_r;

  // held input vertex
  logic [31:0] vx_r, vy_r, vz_r;
  logic        last_r;

  // multiplier and accumulator
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [65:0] prod_r, acc_r;

  // vertex store
  ppc_pkg::vtx_entry_t mem [MAX_VERTS];
  ppc_pkg::vtx_entry_t rd_q;
  ppc_pkg::vtx_entry_t wr_entry;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  // polygon bookkeeping
  logic [CW-1:0]     count_r, nonfront_r, cross_r, idx_r;
  logic              front_r, back_r;
  ppc_pkg::side_t    prev_side_r, first_side_r;
  logic [TW-1:0]     total_r, em_r, total_now;
  logic              wrap_cross;

  // clip walk
  ppc_pkg::vtx_entry_t cur_r, nb_r;
  logic [1:0]          axis_r;
  logic [31:0]         ipt_r [3];
  ppc_pkg::clip_status_t status_r;

  // output register
  logic        ovld_r, opres_r, ofin_r;
  logic [31:0] ox_r, oy_r, oz_r;
  logic [1:0]  ostat_r;
  logic        slot_free;

  // sequencer
  ppc_pkg::ctl_state_t state_r, state_nxt;
  logic                in_take, poly_done;
  logic                emit_en, e_pres, e_fin;
  logic [31:0]         e_x, e_y, e_z;
  ppc_pkg::clip_status_t e_stat;

  // divider
  ppc_pkg::div_ctl_t div_ctl;
  ppc_pkg::div_sts_t div_sts;
  logic [63:0]       div_q;
  logic signed [65:0] prod_mag;
  logic signed [32:0] divisor_s;
  logic [32:0]        divisor_mag;
  logic               q_neg;
  logic [31:0]        q_low, q_signed, ipt_val;

  // distance path
  logic signed [35:0] hi;
  logic signed [36:0] dfull;
  logic [31:0]        dsat;
  logic signed [32:0] d33, eps33;
  ppc_pkg::side_t     new_side;

  // interpolation operands
  logic [31:0]        a_sel, b_sel;
  logic signed [32:0] diff_s;

  assign slot_free = !ovld_r || out_res.ready;
  assign in_take   = in_vtx.valid && in_vtx.ready;

  // ---------------- configuration writes ----------------
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= ppc_pkg::NORMAL_Z_RESET;
      pd_r  <= '0;
      eps_r <= ppc_pkg::EPSILON_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        ppc_pkg::REG_NORMAL_X:   nx_r  <= cfg_wr.data;
        ppc_pkg::REG_NORMAL_Y:   ny_r  <= cfg_wr.data;
        ppc_pkg::REG_NORMAL_Z:   nz_r  <= cfg_wr.data;
        ppc_pkg::REG_PLANE_DIST: pd_r  <= cfg_wr.data;
        ppc_pkg::REG_EPSILON:    eps_r <= cfg_wr.data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- signed distance ----------------
  // floor(sum / 2^30) - d, saturated to 32 bits
  assign hi    = $signed(acc_r[65:30]);
  assign dfull = $signed({hi[35], hi}) - $signed({{5{pd_r[31]}}, pd_r});

  always_comb begin
    if (dfull > 37'sd2147483647)       dsat = 32'h7FFF_FFFF;
    else if (dfull < -37'sd2147483648) dsat = 32'h8000_0000;
    else                               dsat = dfull[31:0];
  end

  assign d33   = $signed({dsat[31], dsat});
  assign eps33 = $signed({17'd0, eps_r});

  always_comb begin
    if (d33 > eps33)       new_side = ppc_pkg::SIDE_FRONT;
    else if (d33 < -eps33) new_side = ppc_pkg::SIDE_BACK;
    else                   new_side = ppc_pkg::SIDE_ON;
  end

  assign wr_entry = '{x: vx_r, y: vy_r, z: vz_r, sdist: dsat, side: new_side};

  // closing edge and output length of a clipped polygon
  assign wrap_cross = ppc_pkg::is_cross(prev_side_r, first_side_r);
  assign total_now  = TW'(nonfront_r) + TW'(cross_r) + TW'(wrap_cross);

  // ---------------- interpolation operands ----------------
  always_comb begin
    unique case (axis_r)
      2'd0:    begin a_sel = cur_r.x; b_sel = nb_r.x; end
      2'd1:    begin a_sel = cur_r.y; b_sel = nb_r.y; end
      default: begin a_sel = cur_r.z; b_sel = nb_r.z; end
    endcase
  end

  assign diff_s    = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
  assign divisor_s = $signed({cur_r.sdist[31], cur_r.sdist}) -
                     $signed({nb_r.sdist[31], nb_r.sdist});
  assign divisor_mag = divisor_s[32] ? 33'(-divisor_s) : divisor_s;
  assign prod_mag    = prod_r[65] ? -prod_r : prod_r;
  assign q_neg       = prod_r[65] ^ divisor_s[32];
  assign q_low       = div_q[31:0];
  assign q_signed    = q_neg ? (~q_low + 32'd1) : q_low;
  assign ipt_val     = a_sel + q_signed;

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_en = 1'b1;
    unique case (state_r)
      ppc_pkg::S_LD_X: begin
        mul_a = $signed({nx_r[31], nx_r}); mul_b = $signed({vx_r[31], vx_r});
      end
      ppc_pkg::S_LD_Y: begin
        mul_a = $signed({ny_r[31], ny_r}); mul_b = $signed({vy_r[31], vy_r});
      end
      ppc_pkg::S_LD_Z: begin
        mul_a = $signed({nz_r[31], nz_r}); mul_b = $signed({vz_r[31], vz_r});
      end
      ppc_pkg::S_C_MUL: begin
        mul_a = $signed({cur_r.sdist[31], cur_r.sdist}); mul_b = diff_s;
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
    unique case (state_r)
      ppc_pkg::S_LD_Y:                   acc_r <= prod_r;
      ppc_pkg::S_LD_Z, ppc_pkg::S_LD_ACC: acc_r <= acc_r + prod_r;
      default: ;
    endcase
  end

  // ---------------- divider ----------------
  assign div_ctl.start = (state_r == ppc_pkg::S_C_DIVGO);

  ppc_div #(
    .DW (64),
    .VW (33)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (prod_mag[63:0]),
    .divisor  (divisor_mag),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // ---------------- vertex store ----------------
  always_ff @(posedge clk) begin
    if (state_r == ppc_pkg::S_LD_WR) mem[count_r[AW-1:0]] <= wr_entry;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // ---------------- sequencer: next state and outputs ----------------
  always_comb begin
    state_nxt    = state_r;
    in_vtx.ready = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_r[AW-1:0];
    emit_en      = 1'b0;
    e_x          = '0;
    e_y          = '0;
    e_z          = '0;
    e_pres       = 1'b0;
    e_fin        = 1'b0;
    e_stat       = ppc_pkg::STAT_CLIPPED;
    poly_done    = 1'b0;

    unique case (state_r)
      ppc_pkg::S_IDLE: begin
        in_vtx.ready = 1'b1;
        if (in_vtx.valid) begin
          if (count_r != CW'(MAX_VERTS))  state_nxt = ppc_pkg::S_LD_X;
          else if (in_vtx.last_vertex)   state_nxt = ppc_pkg::S_CLOSE;
        end
      end
      ppc_pkg::S_LD_X:   state_nxt = ppc_pkg::S_LD_Y;
      ppc_pkg::S_LD_Y:   state_nxt = ppc_pkg::S_LD_Z;
      ppc_pkg::S_LD_Z:   state_nxt = ppc_pkg::S_LD_ACC;
      ppc_pkg::S_LD_ACC: state_nxt = ppc_pkg::S_LD_WR;
      ppc_pkg::S_LD_WR:  state_nxt = last_r ? ppc_pkg::S_CLOSE : ppc_pkg::S_IDLE;
      ppc_pkg::S_CLOSE: begin
        if (!front_r)                     state_nxt = ppc_pkg::S_U_RD;
        else if (!back_r)                 state_nxt = ppc_pkg::S_STAT;
        else if (total_now > TW'(MAX_VERTS)) state_nxt = ppc_pkg::S_STAT;
        else                              state_nxt = ppc_pkg::S_C_RD0;
      end
      // unchanged polygon: stream the store
      ppc_pkg::S_U_RD: begin
        rd_en     = 1'b1;
        state_nxt = ppc_pkg::S_U_EMIT;
      end
      ppc_pkg::S_U_EMIT: begin
        if (slot_free) begin
          emit_en = 1'b1;
          e_x     = rd_q.x;
          e_y     = rd_q.y;
          e_z     = rd_q.z;
          e_pres  = 1'b1;
          e_fin   = (idx_r + CW'(1)) == count_r;
          e_stat  = ppc_pkg::STAT_UNCHANGED;
          if (e_fin) begin
            poly_done = 1'b1;
            state_nxt = ppc_pkg::S_IDLE;
          end else begin
            state_nxt = ppc_pkg::S_U_RD;
          end
        end
      end
      // clipped polygon: walk edges cur -> nb
      ppc_pkg::S_C_RD0: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ppc_pkg::S_C_LD0;
      end
      ppc_pkg::S_C_LD0: state_nxt = ppc_pkg::S_C_RDN;
      ppc_pkg::S_C_RDN: begin
        rd_en     = 1'b1;
        rd_addr   = ((idx_r + CW'(1)) == count_r) ? '0 : AW'(idx_r + CW'(1));
        state_nxt = ppc_pkg::S_C_GOTN;
      end
      ppc_pkg::S_C_GOTN: state_nxt = ppc_pkg::S_C_KEEP;
      ppc_pkg::S_C_KEEP: begin
        if (cur_r.side != ppc_pkg::SIDE_FRONT) begin
          if (slot_free) begin
            emit_en   = 1'b1;
            e_x       = cur_r.x;
            e_y       = cur_r.y;
            e_z       = cur_r.z;
            e_pres    = 1'b1;
            e_fin     = (em_r + TW'(1)) == total_r;
            state_nxt = ppc_pkg::is_cross(cur_r.side, nb_r.side) ?
                        ppc_pkg::S_C_MUL : ppc_pkg::S_C_ADV;
          end
        end else begin
          state_nxt = ppc_pkg::is_cross(cur_r.side, nb_r.side) ?
                      ppc_pkg::S_C_MUL : ppc_pkg::S_C_ADV;
        end
      end
      ppc_pkg::S_C_MUL:   state_nxt = ppc_pkg::S_C_DIVGO;
      ppc_pkg::S_C_DIVGO: state_nxt = ppc_pkg::S_C_DIVW;
      ppc_pkg::S_C_DIVW: begin
        if (div_sts.done) begin
          state_nxt = (axis_r == 2'd2) ? ppc_pkg::S_C_EMI : ppc_pkg::S_C_MUL;
        end
      end
      ppc_pkg::S_C_EMI: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          e_x       = ipt_r[0];
          e_y       = ipt_r[1];
          e_z       = ipt_r[2];
          e_pres    = 1'b1;
          e_fin     = (em_r + TW'(1)) == total_r;
          state_nxt = ppc_pkg::S_C_ADV;
        end
      end
      ppc_pkg::S_C_ADV: begin
        if ((idx_r + CW'(1)) == count_r) begin
          poly_done = 1'b1;
          state_nxt = ppc_pkg::S_IDLE;
        end else begin
          state_nxt = ppc_pkg::S_C_RDN;
        end
      end
      // removed or overflow: one status-only result
      ppc_pkg::S_STAT: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          e_fin     = 1'b1;
          e_stat    = status_r;
          poly_done = 1'b1;
          state_nxt = ppc_pkg::S_IDLE;
        end
      end
      default: state_nxt = ppc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ppc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- polygon bookkeeping ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      nonfront_r   <= '0;
      cross_r      <= '0;
      front_r      <= 1'b0;
      back_r       <= 1'b0;
      prev_side_r  <= ppc_pkg::SIDE_ON;
      first_side_r <= ppc_pkg::SIDE_ON;
      idx_r        <= '0;
      em_r         <= '0;
      total_r      <= '0;
      axis_r       <= '0;
      status_r     <= ppc_pkg::STAT_CLIPPED;
    end else begin
      if (state_r == ppc_pkg::S_LD_WR) begin
        count_r     <= count_r + CW'(1);
        prev_side_r <= new_side;
        if (new_side == ppc_pkg::SIDE_FRONT) front_r <= 1'b1;
        else nonfront_r <= nonfront_r + CW'(1);
        if (new_side == ppc_pkg::SIDE_BACK) back_r <= 1'b1;
        if (count_r == '0) first_side_r <= new_side;
        else if (ppc_pkg::is_cross(prev_side_r, new_side)) cross_r <= cross_r + CW'(1);
      end

      if (state_r == ppc_pkg::S_CLOSE) begin
        idx_r    <= '0;
        em_r     <= '0;
        total_r  <= total_now;
        status_r <= back_r ? ppc_pkg::STAT_OVERFLOW : ppc_pkg::STAT_REMOVED;
      end

      if ((state_r == ppc_pkg::S_U_EMIT) && emit_en) idx_r <= idx_r + CW'(1);
      if ((state_r == ppc_pkg::S_C_ADV) && !poly_done) idx_r <= idx_r + CW'(1);
      if (emit_en && ((state_r == ppc_pkg::S_C_KEEP) || (state_r == ppc_pkg::S_C_EMI))) begin
        em_r <= em_r + TW'(1);
      end

      if (state_r == ppc_pkg::S_C_KEEP) axis_r <= '0;
      if ((state_r == ppc_pkg::S_C_DIVW) && div_sts.done) axis_r <= axis_r + 2'd1;

      if (poly_done) begin
        count_r    <= '0;
        nonfront_r <= '0;
        cross_r    <= '0;
        front_r    <= 1'b0;
        back_r     <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      vx_r   <= in_vtx.vertex_x;
      vy_r   <= in_vtx.vertex_y;
      vz_r   <= in_vtx.vertex_z;
      last_r <= in_vtx.last_vertex;
    end
    if (state_r == ppc_pkg::S_C_LD0) cur_r <= rd_q;
    if (state_r == ppc_pkg::S_C_GOTN) nb_r <= rd_q;
    if ((state_r == ppc_pkg::S_C_ADV) && !poly_done) cur_r <= nb_r;
    if ((state_r == ppc_pkg::S_C_DIVW) && div_sts.done) ipt_r[axis_r] <= ipt_val;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (emit_en) begin
      ovld_r <= 1'b1;
    end else if (out_res.ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      ox_r    <= e_x;
      oy_r    <= e_y;
      oz_r    <= e_z;
      opres_r <= e_pres;
      ofin_r  <= e_fin;
      ostat_r <= e_stat;
    end
  end

  assign out_res.valid          = ovld_r;
  assign out_res.out_x          = ox_r;
  assign out_res.out_y          = oy_r;
  assign out_res.out_z          = oz_r;
  assign out_res.vertex_present = opres_r;
  assign out_res.final_result   = ofin_r;
  assign out_res.clip_status    = ostat_r;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTS))
    else $error("store count above capacity");

  a_nonfront_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nonfront_r <= count_r)
    else $error("kept vertex count above stored count");

  a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cross_r <= count_r)
    else $error("crossing count above edge count");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_en && ((state_r == ppc_pkg::S_C_KEEP) || (state_r == ppc_pkg::S_C_EMI)))
      |-> (em_r < total_r))
    else $error("clipped output longer than precomputed length");

endmodule

// ===== rtl/ppc_div.sv =====
// ----------------------------------------------------------------------------
// ppc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; a start is taken only while idle.
// ----------------------------------------------------------------------------
module ppc_div #(
  parameter int DW = 64,
  parameter int VW = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppc_pkg::div_ctl_t  ctl,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output ppc_pkg::div_sts_t  sts,
  output logic [DW-1:0]      quotient
);

  localparam int CNTW = $clog2(DW);

  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW-1:0]   rem_r;
  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   dsr_r;
  logic [VW:0]     trial;
  logic            take;

  // one restoring step
  assign trial = {rem_r, quo_r[DW-1]};
  assign take  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW - 1);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= take ? VW'(trial - {1'b0, dsr_r}) : trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the polygon plane clipper
// Streams polygons through the clipper under several plane settings, predicts
// every result vertex and status with a bit-exact clipping model and checks
// each result transfer in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic present, fin;
    logic [1:0] status;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppc_vtx_if vtx_ch ();
  ppc_res_if res_ch ();
  ppc_cfg_if cfg_ch ();

  polygon_plane_clipper u_top (
    .clk(clk), .rst_n(rst_n), .in_vtx(vtx_ch.sink),
    .out_res(res_ch.source), .cfg_wr(cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] nrm_x = 0, nrm_y = 0, nrm_z = ppc_pkg::NORMAL_Z_RESET;
  logic signed [31:0] pl_dist = 0;
  logic [15:0] eps = ppc_pkg::EPSILON_RESET;
  logic signed [31:0] poly_x[ppc_pkg::MAX_VERTS], poly_y[ppc_pkg::MAX_VERTS];
  logic signed [31:0] poly_z[ppc_pkg::MAX_VERTS];
  logic signed [31:0] poly_d[ppc_pkg::MAX_VERTS];
  ppc_pkg::side_t poly_side[ppc_pkg::MAX_VERTS];
  int poly_cnt = 0;
  bit seen_front = 0, seen_back = 0;

  clip_res_t expected_q[$];
  int errors = 0;
  int n_results = 0, n_polys = 0, n_clipped = 0, n_overflow = 0;
  int n_removed = 0, n_unchanged = 0;
  int hold_cycles = 0;
  bit random_stall = 1;

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, exp);
    errors++;
  endtask

  function automatic logic signed [31:0] signed_dist(logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z);
    logic signed [95:0] sum;
    logic signed [95:0] q;
    sum = 96'(nrm_x) * 96'(x) + 96'(nrm_y) * 96'(y) + 96'(nrm_z) * 96'(z);
    q = (sum >>> 30) - 96'(pl_dist);
    if (q > 96'sd2147483647) return 32'sh7fffffff;
    if (q < -96'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] edge_point(logic signed [31:0] a,
      logic signed [31:0] b, logic signed [31:0] da, logic signed [31:0] db);
    logic signed [127:0] num, den;
    num = 128'(da) * (128'(b) - 128'(a));
    den = 128'(da) - 128'(db);
    return 32'(128'(a) + num / den);
  endfunction

  function automatic clip_res_t mk(logic signed [31:0] x, y, z, logic p, f,
                                   logic [1:0] s);
    clip_res_t r;
    r.x = x; r.y = y; r.z = z; r.present = p; r.fin = f; r.status = s;
    return r;
  endfunction

  // model one accepted vertex; on the closing vertex queue all results
  task automatic clip_predict(logic signed [31:0] x, y, z, logic last);
    logic signed [31:0] d;
    logic signed [31:0] cx[$], cy[$], cz[$];
    int j;
    if (poly_cnt < ppc_pkg::MAX_VERTS) begin
      d = signed_dist(x, y, z);
      poly_side[poly_cnt] = ppc_pkg::SIDE_ON;
      if (33'(d) > $signed({17'd0, eps})) begin
        poly_side[poly_cnt] = ppc_pkg::SIDE_FRONT; seen_front = 1;
      end else if (33'(d) < -$signed({17'd0, eps})) begin
        poly_side[poly_cnt] = ppc_pkg::SIDE_BACK; seen_back = 1;
      end
      poly_x[poly_cnt] = x; poly_y[poly_cnt] = y; poly_z[poly_cnt] = z;
      poly_d[poly_cnt] = d;
      poly_cnt++;
    end
    if (!last) return;
    n_polys++;
    if (!seen_front) begin
      n_unchanged++;
      for (int i = 0; i < poly_cnt; i++)
        expected_q.push_back(mk(poly_x[i], poly_y[i], poly_z[i], 1,
                                i + 1 == poly_cnt, ppc_pkg::STAT_UNCHANGED));
    end else if (!seen_back) begin
      n_removed++;
      expected_q.push_back(mk(0, 0, 0, 0, 1, ppc_pkg::STAT_REMOVED));
    end else begin
      for (int i = 0; i < poly_cnt; i++) begin
        j = (i + 1 == poly_cnt) ? 0 : i + 1;
        if (poly_side[i] != ppc_pkg::SIDE_FRONT) begin
          cx.push_back(poly_x[i]); cy.push_back(poly_y[i]); cz.push_back(poly_z[i]);
        end
        if (ppc_pkg::is_cross(poly_side[i], poly_side[j])) begin
          cx.push_back(edge_point(poly_x[i], poly_x[j], poly_d[i], poly_d[j]));
          cy.push_back(edge_point(poly_y[i], poly_y[j], poly_d[i], poly_d[j]));
          cz.push_back(edge_point(poly_z[i], poly_z[j], poly_d[i], poly_d[j]));
        end
      end
      if (cx.size() > ppc_pkg::MAX_VERTS) begin
        n_overflow++;
        expected_q.push_back(mk(0, 0, 0, 0, 1, ppc_pkg::STAT_OVERFLOW));
      end else begin
        n_clipped++;
        foreach (cx[k])
          expected_q.push_back(mk(cx[k], cy[k], cz[k], 1, k + 1 == cx.size(),
                                  ppc_pkg::STAT_CLIPPED));
      end
    end
    poly_cnt = 0; seen_front = 0; seen_back = 0;
  endtask

  // input side
  initial begin
    vtx_ch.valid = 0; vtx_ch.vertex_x = 0; vtx_ch.vertex_y = 0;
    vtx_ch.vertex_z = 0; vtx_ch.last_vertex = 0;
    cfg_ch.valid = 0; cfg_ch.index = ppc_pkg::REG_NORMAL_X; cfg_ch.data = 0;
  end

  // driven at the falling edge; a following transfer may start at the same edge
  task automatic send_vertex(logic signed [31:0] x, y, z, logic last, bit gaps = 1);
    if (gaps) repeat ($urandom_range(0, 19)) @(negedge clk);
    vtx_ch.valid = 1; vtx_ch.vertex_x = x; vtx_ch.vertex_y = y;
    vtx_ch.vertex_z = z; vtx_ch.last_vertex = last;
    @(posedge clk);
    while (!vtx_ch.ready) @(posedge clk);
    clip_predict(x, y, z, last);
    @(negedge clk);
    vtx_ch.valid = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid = 1; cfg_ch.index = idx; cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ppc_pkg::REG_NORMAL_X:   nrm_x = val;
      ppc_pkg::REG_NORMAL_Y:   nrm_y = val;
      ppc_pkg::REG_NORMAL_Z:   nrm_z = val;
      ppc_pkg::REG_PLANE_DIST: pl_dist = val;
      default:                 eps = val[15:0];
    endcase
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic set_plane(logic [31:0] nx, ny, nz, pd, logic [15:0] e);
    wait_idle();
    write_reg(ppc_pkg::REG_NORMAL_X, nx);
    write_reg(ppc_pkg::REG_NORMAL_Y, ny);
    write_reg(ppc_pkg::REG_NORMAL_Z, nz);
    write_reg(ppc_pkg::REG_PLANE_DIST, pd);
    write_reg(ppc_pkg::REG_EPSILON, {16'd0, e});
  endtask

  // random coordinate: mostly modest values, sometimes the full range
  function automatic logic signed [31:0] rnd_coord();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  task automatic send_polygon(int n, bit gaps = 1);
    for (int i = 0; i < n; i++)
      send_vertex(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1, gaps);
  endtask

  // result side
  initial begin
    res_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready <= 0; hold_cycles--;
      end else if (random_stall && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 0;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end else begin
        res_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    clip_res_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("MISMATCH unexpected result %0d", n_results);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.out_x !== e.x) report_mismatch("out_x", res_ch.out_x, e.x);
        if (res_ch.out_y !== e.y) report_mismatch("out_y", res_ch.out_y, e.y);
        if (res_ch.out_z !== e.z) report_mismatch("out_z", res_ch.out_z, e.z);
        if (res_ch.vertex_present !== e.present)
          report_mismatch("vertex_present", res_ch.vertex_present, e.present);
        if (res_ch.final_result !== e.fin)
          report_mismatch("final_result", res_ch.final_result, e.fin);
        if (res_ch.clip_status !== e.status)
          report_mismatch("clip_status", res_ch.clip_status, e.status);
      end
    end
  end

  // directed: triangle straddling z = 0 plus the three special outcomes
  task automatic test_directed();
    send_vertex(32'sh0001_0000, 0, 32'sh0001_0000, 0);
    send_vertex(0, 32'sh0001_0000, -32'sh0001_0000, 0);
    send_vertex(-32'sh0001_0000, 0, -32'sh0002_0000, 1);
    // all behind: unchanged
    send_vertex(1, 2, -32'sh0001_0000, 0);
    send_vertex(3, 4, -32'sh0003_0000, 1);
    // all on plane within epsilon
    send_vertex(32'sh7fffffff, 32'sh80000000, 66, 0);
    send_vertex(32'sh80000000, 32'sh7fffffff, -66, 1);
    // all in front: removed
    send_vertex(0, 0, 32'sh7fffffff, 0);
    send_vertex(-1, -1, 67, 1);
    // extreme z at both ends, crossing edge with full-range distances
    send_vertex(-1, -1, 32'sh80000000, 0);
    send_vertex(32'sh7fffffff, 0, 32'sh7fffffff, 0);
    send_vertex(0, 0, 0, 1);
    // single vertex polygon
    send_vertex(5, 6, -32'sh0000_1000, 1);
  endtask

  // zigzag polygon of 32 vertices: every edge crosses, output exceeds the store
  task automatic test_overflow();
    for (int i = 0; i < ppc_pkg::MAX_VERTS; i++)
      send_vertex(rnd_coord(), rnd_coord(), (i % 2) ? 32'sh0001_0000 : -32'sh0001_0000,
                  i == ppc_pkg::MAX_VERTS - 1);
  endtask

  // more vertices than the store holds; extras are dropped
  task automatic test_too_many();
    send_polygon(ppc_pkg::MAX_VERTS + 4, 0);
  endtask

  // receiver holds off while polygons keep arriving
  task automatic test_backpressure();
    hold_cycles = 1500;
    repeat (4) send_polygon(5, 0);
  endtask

  task automatic test_random(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 34) : $urandom_range(3, 8);
      send_polygon(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (2) @(negedge clk);
    test_directed();
    test_overflow();
    test_too_many();
    test_backpressure();
    test_random(30);
    // oblique plane, offset, zero epsilon
    set_plane(32'h2d41_3ccd, 32'hd2be_c333, 32'h0000_0000, 32'h0001_8000, 16'd0);
    test_random(20);
    // extreme register values
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h8000_0000, 16'hffff);
    test_random(15);
    set_plane($urandom, $urandom, $urandom, $urandom, $urandom);
    test_directed();
    test_random(20);
    wait_idle();
    $display("Covered %0d polygons, %0d results: %0d clipped, %0d unchanged,",
             n_polys, n_results, n_clipped, n_unchanged);
    $display("%0d removed, %0d overflow, under four plane settings.", n_removed, n_overflow);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
